// ----- hdl/acbc_pkg.sv -----
package acbc_pkg;

  // One 16-byte block, byte 0 in the most significant bits.
  typedef logic [0:15][7:0] blk_t;
  // Key schedule window and key words, word 0 first.
  typedef logic [0:7][31:0] kwin_t;
  typedef logic [0:3][31:0] kquad_t;

  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_IV_HI  = 3'd4,
    REG_IV_LO  = 3'd5,
    REG_KSIZE  = 3'd6,
    REG_DIR    = 3'd7
  } reg_idx_e;

  localparam int RkDepth = 15;
  localparam int RkAw    = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;
    logic            exp;
    logic            exp_first;
    logic            pre;
    logic            ark;
    logic            round;
    logic            last;
    logic            finish;
    logic [RkAw-1:0] rk_addr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [3:0] nr;
    logic       dir;
    logic       key_wr;
    logic       out_busy;
  } sts_t;

  localparam logic [0:255][7:0] SBOX = {
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [0:255][7:0] INV_SBOX = {
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Multiply by a constant below 16, given as its bits.
  function automatic logic [7:0] mulc(logic [7:0] a, logic [3:0] k);
    logic [7:0] x2;
    logic [7:0] x4;
    logic [7:0] x8;
    x2 = xt(a);
    x4 = xt(x2);
    x8 = xt(x4);
    return (k[0] ? a : 8'h00) ^ (k[1] ? x2 : 8'h00) ^
           (k[2] ? x4 : 8'h00) ^ (k[3] ? x8 : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic blk_t sub_blk(blk_t s, logic inv);
    blk_t o;
    for (int k = 0; k < 16; k++) begin
      o[k] = inv ? INV_SBOX[s[k]] : SBOX[s[k]];
    end
    return o;
  endfunction

  function automatic blk_t shift_blk(blk_t s, logic inv);
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          o[4 * ((c + r) & 3) + r] = s[4 * c + r];
        end else begin
          o[4 * c + r] = s[4 * ((c + r) & 3) + r];
        end
      end
    end
    return o;
  endfunction

  function automatic blk_t mix_blk(blk_t s, logic inv);
    blk_t o;
    logic [3:0] m0;
    logic [3:0] m1;
    logic [3:0] m2;
    logic [3:0] m3;
    logic [7:0] a0;
    logic [7:0] a1;
    logic [7:0] a2;
    logic [7:0] a3;
    m0 = inv ? 4'd14 : 4'd2;
    m1 = inv ? 4'd11 : 4'd3;
    m2 = inv ? 4'd13 : 4'd1;
    m3 = inv ? 4'd9  : 4'd1;
    for (int c = 0; c < 4; c++) begin
      a0 = s[4 * c];
      a1 = s[4 * c + 1];
      a2 = s[4 * c + 2];
      a3 = s[4 * c + 3];
      o[4 * c]     = mulc(a0, m0) ^ mulc(a1, m1) ^ mulc(a2, m2) ^ mulc(a3, m3);
      o[4 * c + 1] = mulc(a0, m3) ^ mulc(a1, m0) ^ mulc(a2, m1) ^ mulc(a3, m2);
      o[4 * c + 2] = mulc(a0, m2) ^ mulc(a1, m3) ^ mulc(a2, m0) ^ mulc(a3, m1);
      o[4 * c + 3] = mulc(a0, m1) ^ mulc(a1, m2) ^ mulc(a2, m3) ^ mulc(a3, m0);
    end
    return o;
  endfunction

endpackage

// ----- hdl/acbc_dp.sv -----
module acbc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  acbc_pkg::cmd_t      cmd_i,
  output acbc_pkg::sts_t      sts_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_wdata_i,
  input  logic                first_block_i,
  input  logic [63:0]         data_high_i,
  input  logic [63:0]         data_low_i,
  input  logic [4:0]          valid_bytes_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [63:0]         result_high_o,
  output logic [63:0]         result_low_o
);

  logic [63:0] key0_q, key1_q, key2_q, key3_q, iv_hi_q, iv_lo_q;
  logic [1:0]  ksize_q;
  logic        dir_q;

  logic              first_q;
  logic [4:0]        vb_q;
  acbc_pkg::blk_t    blk_in_q;
  acbc_pkg::blk_t    state_q, state_d;
  acbc_pkg::blk_t    chain_q, chain_d;
  acbc_pkg::blk_t    res_q;
  logic              out_valid_q;
  acbc_pkg::blk_t    rk_rd_q;
  logic [127:0]      rk_mem [acbc_pkg::RkDepth];

  acbc_pkg::kwin_t   win_q;
  acbc_pkg::kwin_t   key_words;
  acbc_pkg::kquad_t  nw;
  logic [2:0]        ph_q;
  logic [7:0]        rcon_q;
  logic [3:0]        ph_n;
  logic [7:0]        rcon_n;
  logic [3:0]        nk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
      key3_q  <= '0;
      iv_hi_q <= '0;
      iv_lo_q <= '0;
      ksize_q <= '0;
      dir_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (acbc_pkg::reg_idx_e'(cfg_index_i))
        acbc_pkg::REG_KEY0:  key0_q  <= cfg_wdata_i;
        acbc_pkg::REG_KEY1:  key1_q  <= cfg_wdata_i;
        acbc_pkg::REG_KEY2:  key2_q  <= cfg_wdata_i;
        acbc_pkg::REG_KEY3:  key3_q  <= cfg_wdata_i;
        acbc_pkg::REG_IV_HI: iv_hi_q <= cfg_wdata_i;
        acbc_pkg::REG_IV_LO: iv_lo_q <= cfg_wdata_i;
        acbc_pkg::REG_KSIZE: ksize_q <= cfg_wdata_i[1:0];
        acbc_pkg::REG_DIR:   dir_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ksize_q)
      2'd0:    nk = 4'd4;
      2'd1:    nk = 4'd6;
      default: nk = 4'd8;
    endcase
  end

  assign key_words = {key0_q, key1_q, key2_q, key3_q};

  // Four schedule words per step; the window holds the eight words before them.
  always_comb begin
    logic [31:0] prev;
    logic [31:0] t;
    logic [5:0]  iw;
    logic [3:0]  m;
    logic [3:0]  ph_e;
    logic [7:0]  rcon_e;
    logic [2:0]  widx;
    logic        rc_adv;
    ph_e   = cmd_i.exp_first ? 4'd0 : {1'b0, ph_q};
    rcon_e = cmd_i.exp_first ? 8'h01 : rcon_q;
    prev   = win_q[7];
    rc_adv = 1'b0;
    for (int j = 0; j < 4; j++) begin
      iw   = {cmd_i.rk_addr, 2'b00} + 6'(j);
      m    = ph_e + 4'(j);
      if (m >= nk) begin
        m = m - nk;
      end
      widx = 3'(4'(j) + 4'd8 - nk);
      t    = prev;
      if (iw < {2'b00, nk}) begin
        nw[j] = key_words[iw[2:0]];
      end else begin
        if (m == 4'd0) begin
          t      = acbc_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rcon_e, 24'h0};
          rc_adv = 1'b1;
        end else if (nk == 4'd8 && m == 4'd4) begin
          t = acbc_pkg::sub_word(prev);
        end
        nw[j] = win_q[widx] ^ t;
      end
      prev = nw[j];
    end
    ph_n = ph_e + 4'd4;
    if (ph_n >= nk) begin
      ph_n = ph_n - nk;
    end
    rcon_n = rc_adv ? acbc_pkg::xt(rcon_e) : rcon_e;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp) begin
      win_q  <= {win_q[4:7], nw};
      ph_q   <= ph_n[2:0];
      rcon_q <= rcon_n;
      rk_mem[cmd_i.rk_addr] <= nw;
    end
    rk_rd_q <= rk_mem[cmd_i.rk_addr];
  end

  // Round and block preparation.
  always_comb begin
    acbc_pkg::blk_t ch_e;
    acbc_pkg::blk_t msk;
    acbc_pkg::blk_t et;
    acbc_pkg::blk_t eo;
    acbc_pkg::blk_t dt;
    acbc_pkg::blk_t da;
    acbc_pkg::blk_t dout;
    ch_e = first_q ? acbc_pkg::blk_t'({iv_hi_q, iv_lo_q}) : chain_q;
    for (int k = 0; k < 16; k++) begin
      msk[k] = (5'(k) < vb_q) ? blk_in_q[k] : 8'h00;
    end
    et   = acbc_pkg::shift_blk(acbc_pkg::sub_blk(state_q, 1'b0), 1'b0);
    eo   = (cmd_i.last ? et : acbc_pkg::mix_blk(et, 1'b0)) ^ rk_rd_q;
    dt   = acbc_pkg::sub_blk(acbc_pkg::shift_blk(state_q, 1'b1), 1'b1);
    da   = dt ^ rk_rd_q;
    dout = cmd_i.last ? da : acbc_pkg::mix_blk(da, 1'b1);
    state_d = state_q;
    chain_d = chain_q;
    if (cmd_i.pre) begin
      chain_d = ch_e;
      state_d = dir_q ? blk_in_q : (msk ^ ch_e);
    end else if (cmd_i.ark) begin
      state_d = state_q ^ rk_rd_q;
    end else if (cmd_i.round) begin
      state_d = dir_q ? dout : eo;
    end
    if (cmd_i.finish) begin
      chain_d = dir_q ? blk_in_q : state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_q  <= first_block_i;
      vb_q     <= valid_bytes_i;
      blk_in_q <= {data_high_i, data_low_i};
    end
    state_q <= state_d;
    if (cmd_i.finish) begin
      res_q <= dir_q ? (state_d ^ chain_q) : state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      chain_q <= chain_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.nr       = nk + 4'd6;
  assign sts_o.dir      = dir_q;
  assign sts_o.key_wr   = cfg_we_i && (cfg_index_i == acbc_pkg::REG_KEY0 ||
                          cfg_index_i == acbc_pkg::REG_KEY1 ||
                          cfg_index_i == acbc_pkg::REG_KEY2 ||
                          cfg_index_i == acbc_pkg::REG_KEY3 ||
                          cfg_index_i == acbc_pkg::REG_KSIZE);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign result_high_o = res_q[0:7];
  assign result_low_o  = res_q[8:15];

endmodule

// ----- hdl/acbc_ctrl.sv -----
module acbc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  acbc_pkg::sts_t sts_i,
  output acbc_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_ARK    = 5'b01000,
    ST_ROUND  = 5'b10000
  } state_e;

  state_e     st_q, st_d;
  logic [3:0] cnt_q, cnt_d;
  logic       stale_q, stale_d;
  logic       accept;
  logic       last;

  function automatic logic [3:0] kaddr(logic dir, logic [3:0] nr, logic [3:0] k);
    return dir ? (nr - k) : k;
  endfunction

  assign in_ready_o = (st_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (cnt_q == sts_i.nr);

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    stale_d = stale_q || sts_i.key_wr;
    cmd_o   = '0;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = 4'd0;
          st_d       = stale_q ? ST_EXPAND : ST_LOAD;
        end
      end
      ST_EXPAND: begin
        cmd_o.exp       = 1'b1;
        cmd_o.exp_first = (cnt_q == 4'd0);
        cmd_o.rk_addr   = cnt_q;
        if (last) begin
          stale_d = sts_i.key_wr;
          cnt_d   = 4'd0;
          st_d    = ST_LOAD;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_LOAD: begin
        cmd_o.pre     = 1'b1;
        cmd_o.rk_addr = kaddr(sts_i.dir, sts_i.nr, 4'd0);
        st_d          = ST_ARK;
      end
      ST_ARK: begin
        cmd_o.ark     = 1'b1;
        cmd_o.rk_addr = kaddr(sts_i.dir, sts_i.nr, 4'd1);
        cnt_d         = 4'd1;
        st_d          = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.last = last;
        if (last) begin
          // The final key stays addressed so a stall keeps it on the read port.
          cmd_o.rk_addr = kaddr(sts_i.dir, sts_i.nr, cnt_q);
          if (!sts_i.out_busy) begin
            cmd_o.round  = 1'b1;
            cmd_o.finish = 1'b1;
            st_d         = ST_IDLE;
          end
        end else begin
          cmd_o.round   = 1'b1;
          cmd_o.rk_addr = kaddr(sts_i.dir, sts_i.nr, cnt_q + 4'd1);
          cnt_d         = cnt_q + 4'd1;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      cnt_q   <= 4'd0;
      stale_q <= 1'b1;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      stale_q <= stale_d;
    end
  end

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !sts_i.out_busy)
    else $error("result written while output register is occupied");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (st_q == ST_EXPAND || st_q == ST_LOAD))
    else $error("accepted block did not start");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EXPAND || st_q == ST_ROUND) |-> cnt_q <= sts_i.nr)
    else $error("round counter beyond round count");

endmodule

// ----- hdl/aes_cbc_cipher.sv -----
// AES-CBC cipher for 128-, 192- and 256-bit keys. Each request carries one
// 16-byte block; first_block_i restarts the chain from the IV registers, and
// when encrypting, bytes past valid_bytes_i are zeroed before chaining. The
// result register is loaded after a load step, an initial key addition and
// Nr rounds, and the next request can be accepted once the controller is
// back in idle. The single round unit runs one AES round per cycle, but the
// last round can stall as told below. After reset or any write to a key word
// or the key size, the first block first builds the round key memory, one
// round key per cycle. A new request is taken as soon as the previous block
// has left the round unit, while its result may still wait in the output
// register; a block whose result would overwrite a waiting one holds in its
// last round until the output register is free. The user must write the
// configuration only while the block idles; the block does not enforce this.
module aes_cbc_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        first_block_i,
  input  logic [63:0] data_high_i,
  input  logic [63:0] data_low_i,
  input  logic [4:0]  valid_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);

  acbc_pkg::cmd_t cmd;
  acbc_pkg::sts_t sts;

  // The controller sequences key expansion and the rounds.
  acbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the registers, the round key memory and the chain.
  acbc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .first_block_i (first_block_i),
    .data_high_i   (data_high_i),
    .data_low_i    (data_low_i),
    .valid_bytes_i (valid_bytes_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_high_o (result_high_o),
    .result_low_o  (result_low_o)
  );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

  // Clock, reset and block ports.
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        first_block_i;
  logic [63:0] data_high_i;
  logic [63:0] data_low_i;
  logic [4:0]  valid_bytes_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;

  aes_cbc_cipher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .first_block_i (first_block_i),
    .data_high_i   (data_high_i),
    .data_low_i    (data_low_i),
    .valid_bytes_i (valid_bytes_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_high_o (result_high_o),
    .result_low_o  (result_low_o)
  );

  // One block request.
  typedef struct {
    logic        first;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nvalid;
  } blk_req_t;

  // A row of the directed table. When has_gold is set, the typed-in ciphertext
  // or plaintext is checked in addition to the predicted one.
  typedef struct {
    blk_req_t    req;
    logic        has_gold;
    logic [63:0] gold_hi;
    logic [63:0] gold_lo;
  } dir_row_t;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int NUM_RANDOM   = 830;

  // Shadow copy of the configuration and of the chaining value.
  logic [63:0] key_sh [4];
  logic [63:0] iv_hi_sh;
  logic [63:0] iv_lo_sh;
  logic [1:0]  ksize_sh;
  logic        decrypt_sh;
  logic [63:0] chain_hi;
  logic [63:0] chain_lo;

  // Blocks that are expected on the result port, oldest first.
  logic [127:0] pending_blocks[$];
  // Typed-in answers for directed rows, aligned with pending_blocks.
  logic [128:0] known_answers[$];

  int mismatches;
  int blocks_checked;
  int cycle_count;
  int enc_blocks;
  int dec_blocks;
  bit quiet_mode;

  // GF(2^8) product, written bit-serially.
  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] p;
    x = {1'b0, a};
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= x[7:0];
      x = x << 1;
      if (x[8]) x ^= 9'h11b;
    end
    return p;
  endfunction

  // The S-box built from the field inverse and the affine map.
  function automatic logic [7:0] sbox_fwd(logic [7:0] v);
    logic [7:0] r;
    logic [7:0] b;
    logic [7:0] e;
    r = 8'h01;
    b = v;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul(r, b);
      b = gmul(b, b);
    end
    // r is now v^254, the inverse (zero maps to zero).
    e = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]};
    return e ^ 8'h63;
  endfunction

  function automatic logic [7:0] sbox_inv(logic [7:0] y);
    logic [7:0] b;
    logic [7:0] r;
    logic [7:0] s;
    b = {y[6:0], y[7]} ^ {y[4:0], y[7:5]} ^ {y[1:0], y[7:2]} ^ 8'h05;
    r = 8'h01;
    s = b;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul(r, s);
      s = gmul(s, s);
    end
    return r;
  endfunction

  logic [7:0] fwd_tab [256];
  logic [7:0] inv_tab [256];

  // Round keys for the current key, as 32-bit words.
  logic [31:0] rkey [60];
  int          nrounds;

  task automatic build_schedule();
    int nk;
    logic [31:0] t;
    logic [7:0] rc;
    nk = (ksize_sh == 2'd0) ? 4 : (ksize_sh == 2'd1) ? 6 : 8;
    nrounds = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++) begin
      rkey[i] = i[0] ? key_sh[i >> 1][31:0] : key_sh[i >> 1][63:32];
    end
    for (int i = nk; i < 4 * (nrounds + 1); i++) begin
      t = rkey[i - 1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
      end
      rkey[i] = rkey[i - nk] ^ t;
    end
  endtask

  function automatic acbc_pkg::blk_t add_key(acbc_pkg::blk_t s, int rnd);
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        s[4 * c + r] ^= rkey[4 * rnd + c][31 - 8 * r -: 8];
      end
    end
    return s;
  endfunction

  function automatic acbc_pkg::blk_t rotate_rows(acbc_pkg::blk_t s, bit inv);
    acbc_pkg::blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) o[4 * ((c + r) & 3) + r] = s[4 * c + r];
        else o[4 * c + r] = s[4 * ((c + r) & 3) + r];
      end
    end
    return o;
  endfunction

  function automatic acbc_pkg::blk_t mix_cols(acbc_pkg::blk_t s, bit inv);
    acbc_pkg::blk_t o;
    logic [7:0] m0, m1, m2, m3;
    m0 = inv ? 8'd14 : 8'd2;
    m1 = inv ? 8'd11 : 8'd3;
    m2 = inv ? 8'd13 : 8'd1;
    m3 = inv ? 8'd9 : 8'd1;
    for (int c = 0; c < 4; c++) begin
      o[4*c]   = gmul(s[4*c], m0) ^ gmul(s[4*c+1], m1) ^ gmul(s[4*c+2], m2) ^ gmul(s[4*c+3], m3);
      o[4*c+1] = gmul(s[4*c], m3) ^ gmul(s[4*c+1], m0) ^ gmul(s[4*c+2], m1) ^ gmul(s[4*c+3], m2);
      o[4*c+2] = gmul(s[4*c], m2) ^ gmul(s[4*c+1], m3) ^ gmul(s[4*c+2], m0) ^ gmul(s[4*c+3], m1);
      o[4*c+3] = gmul(s[4*c], m1) ^ gmul(s[4*c+1], m2) ^ gmul(s[4*c+2], m3) ^ gmul(s[4*c+3], m0);
    end
    return o;
  endfunction

  function automatic acbc_pkg::blk_t cipher_fwd(acbc_pkg::blk_t s);
    s = add_key(s, 0);
    for (int rnd = 1; rnd <= nrounds; rnd++) begin
      for (int i = 0; i < 16; i++) s[i] = fwd_tab[s[i]];
      s = rotate_rows(s, 1'b0);
      if (rnd != nrounds) s = mix_cols(s, 1'b0);
      s = add_key(s, rnd);
    end
    return s;
  endfunction

  function automatic acbc_pkg::blk_t cipher_inv(acbc_pkg::blk_t s);
    s = add_key(s, nrounds);
    for (int rnd = nrounds - 1; rnd >= 0; rnd--) begin
      s = rotate_rows(s, 1'b1);
      for (int i = 0; i < 16; i++) s[i] = inv_tab[s[i]];
      s = add_key(s, rnd);
      if (rnd != 0) s = mix_cols(s, 1'b1);
    end
    return s;
  endfunction

  // Computes the CBC output for one accepted request and advances the chain.
  function automatic logic [127:0] cbc_predict(blk_req_t q);
    acbc_pkg::blk_t blk;
    acbc_pkg::blk_t res;
    int   count;
    if (q.first) begin
      chain_hi = iv_hi_sh;
      chain_lo = iv_lo_sh;
    end
    blk = {q.hi, q.lo};
    if (!decrypt_sh) begin
      // Bytes past the valid count become padding; counts above 16 saturate.
      count = (q.nvalid > 5'd16) ? 16 : int'(q.nvalid);
      for (int i = count; i < 16; i++) blk[i] = 8'h00;
      res = cipher_fwd(blk ^ {chain_hi, chain_lo});
      {chain_hi, chain_lo} = res;
    end else begin
      res = cipher_inv(blk) ^ {chain_hi, chain_lo};
      chain_hi = q.hi;
      chain_lo = q.lo;
    end
    return res;
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Register write during idle; the shadow copy follows it.
  task automatic write_reg(acbc_pkg::reg_idx_e idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      acbc_pkg::REG_KEY0, acbc_pkg::REG_KEY1,
      acbc_pkg::REG_KEY2, acbc_pkg::REG_KEY3: key_sh[idx] = val;
      acbc_pkg::REG_IV_HI: iv_hi_sh = val;
      acbc_pkg::REG_IV_LO: iv_lo_sh = val;
      acbc_pkg::REG_KSIZE: ksize_sh = val[1:0];
      acbc_pkg::REG_DIR:   decrypt_sh = val[0];
      default: ;
    endcase
    build_schedule();
    @(negedge clk_i);
  endtask

  // Drives one request: an idle gap first, then valid held until accepted.
  task automatic send_block(blk_req_t q, logic has_gold, logic [127:0] gold);
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    first_block_i <= q.first;
    data_high_i   <= q.hi;
    data_low_i    <= q.lo;
    valid_bytes_i <= q.nvalid;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_blocks.push_back(cbc_predict(q));
    known_answers.push_back({has_gold, gold});
    if (decrypt_sh) dec_blocks++;
    else enc_blocks++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits until every expected result has arrived, plus a quiet margin.
  task automatic drain();
    while (pending_blocks.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Result side: random stalls, sampled at the rising edge.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    logic [127:0] want;
    logic [128:0] gold;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result %h %h", result_high_o, result_low_o);
        end
      end else begin
        want = pending_blocks.pop_front();
        gold = known_answers.pop_front();
        blocks_checked++;
        if (result_high_o !== want[127:64] || result_low_o !== want[63:0] ||
            (gold[128] && want !== gold[127:0])) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on block %0d: expected %h %h (typed %h), got %h %h",
                     blocks_checked, want[127:64], want[63:0], gold[127:0],
                     result_high_o, result_low_o);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Directed table. The typed-in answers are the standard published vectors:
  // after the row straight out of reset, three rows are single-block
  // encryptions under each key size with the IV still at zero; the rest are
  // checked only against the predictor.
  dir_row_t dir_rows [$];

  task automatic add_row(logic first, logic [63:0] hi, logic [63:0] lo, logic [4:0] nv);
    dir_row_t row;
    row.req      = '{first, hi, lo, nv};
    row.has_gold = 1'b0;
    row.gold_hi  = '0;
    row.gold_lo  = '0;
    dir_rows.push_back(row);
  endtask

  task automatic run_table();
    foreach (dir_rows[i]) begin
      send_block(dir_rows[i].req, dir_rows[i].has_gold,
                 {dir_rows[i].gold_hi, dir_rows[i].gold_lo});
    end
    dir_rows.delete();
  endtask

  function automatic blk_req_t random_req(bit first);
    blk_req_t q;
    q.first  = first;
    q.hi     = {$urandom, $urandom};
    q.lo     = {$urandom, $urandom};
    // Mostly full blocks, with short, zero and over-range counts mixed in.
    case ($urandom_range(0, 9))
      0, 1: q.nvalid = 5'($urandom_range(0, 16));
      2:    q.nvalid = 5'($urandom_range(17, 31));
      default: q.nvalid = 5'd16;
    endcase
    if ($urandom_range(0, 15) == 0) q.hi = '1;
    if ($urandom_range(0, 15) == 0) q.lo = '0;
    return q;
  endfunction

  task automatic random_config();
    write_reg(acbc_pkg::REG_KEY0, {$urandom, $urandom});
    write_reg(acbc_pkg::REG_KEY1, {$urandom, $urandom});
    write_reg(acbc_pkg::REG_KEY2, {$urandom, $urandom});
    write_reg(acbc_pkg::REG_KEY3, {$urandom, $urandom});
    write_reg(acbc_pkg::REG_IV_HI, {$urandom, $urandom});
    write_reg(acbc_pkg::REG_IV_LO, {$urandom, $urandom});
    write_reg(acbc_pkg::REG_KSIZE, 64'($urandom_range(0, 3)));
    write_reg(acbc_pkg::REG_DIR, 64'($urandom_range(0, 1)));
  endtask

  initial begin
    dir_row_t row;
    blk_req_t q;
    int sent;
    int msg_len;
    mismatches     = 0;
    blocks_checked = 0;
    cycle_count    = 0;
    enc_blocks     = 0;
    dec_blocks     = 0;
    quiet_mode     = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = acbc_pkg::REG_KEY0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    first_block_i = 1'b0;
    data_high_i   = '0;
    data_low_i    = '0;
    valid_bytes_i = 5'd16;
    for (int i = 0; i < 4; i++) key_sh[i] = '0;
    iv_hi_sh   = '0;
    iv_lo_sh   = '0;
    ksize_sh   = 2'd0;
    decrypt_sh = 1'b0;
    chain_hi   = '0;
    chain_lo   = '0;
    for (int i = 0; i < 256; i++) begin
      fwd_tab[i] = sbox_fwd(8'(i));
      inv_tab[i] = sbox_inv(8'(i));
    end
    build_schedule();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Straight after reset: zero key, zero chain, no first-block flag.
    // AES-128 of the zero block under the zero key is a well-known value.
    row.req = '{1'b0, 64'h0, 64'h0, 5'd16};
    row.has_gold = 1'b1;
    row.gold_hi = 64'h66e94bd4ef8a2c3b;
    row.gold_lo = 64'h884cfa59ca342b2e;
    dir_rows.push_back(row);
    run_table();
    drain();

    // Standard single-block vectors for each key size, with a zero IV.
    write_reg(acbc_pkg::REG_KEY0, 64'h0001020304050607);
    write_reg(acbc_pkg::REG_KEY1, 64'h08090a0b0c0d0e0f);
    write_reg(acbc_pkg::REG_KEY2, 64'h1011121314151617);
    write_reg(acbc_pkg::REG_KEY3, 64'h18191a1b1c1d1e1f);
    for (int ks = 0; ks < 3; ks++) begin
      write_reg(acbc_pkg::REG_KSIZE, 64'(ks));
      row.req = '{1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16};
      row.has_gold = 1'b1;
      case (ks)
        0: {row.gold_hi, row.gold_lo} = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
        1: {row.gold_hi, row.gold_lo} = 128'hdda97ca4864cdfe06eaf70a0ec0d7191;
        default: {row.gold_hi, row.gold_lo} = 128'h8ea2b7ca516745bfeafc49904b496089;
      endcase
      dir_rows.push_back(row);
      run_table();
      drain();
    end

    // Key size code 3 behaves as 256; extremes of data and of the valid count.
    write_reg(acbc_pkg::REG_KSIZE, 64'd3);
    write_reg(acbc_pkg::REG_IV_HI, '1);
    write_reg(acbc_pkg::REG_IV_LO, 64'h0123456789abcdef);
    add_row(1'b1, '1, '1, 5'd16);
    add_row(1'b0, '0, '0, 5'd0);
    add_row(1'b0, '1, '1, 5'd1);
    add_row(1'b0, '1, '1, 5'd15);
    add_row(1'b0, '1, '1, 5'd17);
    add_row(1'b0, '1, '1, 5'd31);
    add_row(1'b0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd8);
    run_table();
    drain();

    // An IV written in mid-message only counts from the next first block.
    write_reg(acbc_pkg::REG_IV_LO, '0);
    add_row(1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd16);
    add_row(1'b1, 64'h1, 64'h2, 5'd16);
    run_table();
    drain();

    // Decryption with each key size; the valid count is ignored.
    write_reg(acbc_pkg::REG_DIR, 64'd1);
    for (int ks = 0; ks < 3; ks++) begin
      write_reg(acbc_pkg::REG_KSIZE, 64'(ks));
      add_row(1'b1, '1, '1, 5'd0);
      add_row(1'b0, '0, '0, 5'd3);
      add_row(1'b0, 64'h8000000000000001, 64'h7ffffffffffffffe, 5'd31);
      run_table();
      drain();
    end
    write_reg(acbc_pkg::REG_DIR, 64'd0);

    // Random part: phases of messages under random keys, key sizes, IVs and
    // directions, each phase drained before the next configuration.
    sent = 0;
    while (sent < NUM_RANDOM) begin
      if (sent > NUM_RANDOM - 120) quiet_mode = 1'b1;
      random_config();
      for (int m = 0; m < 6 && sent < NUM_RANDOM; m++) begin
        msg_len = $urandom_range(1, 8);
        for (int b = 0; b < msg_len; b++) begin
          // A few messages run on without the first-block flag.
          q = random_req(b == 0 && $urandom_range(0, 9) != 0);
          send_block(q, 1'b0, '0);
          sent++;
        end
      end
      drain();
    end
    drain();

    $display("Covered %0d encrypted and %0d decrypted blocks, %0d results checked,",
             enc_blocks, dec_blocks, blocks_checked);
    $display("over all three key sizes, short and saturated counts, and IV reloads.");
    if (mismatches == 0 && pending_blocks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/acbc_pkg.sv
hdl/acbc_dp.sv
hdl/acbc_ctrl.sv
hdl/aes_cbc_cipher.sv
dv/tb.sv
